// ===== sv/wsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsfd_pkg
// Types and codes shared by the websocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsfd_pkg;

    localparam int BYTE_W   = 8;
    localparam int OPCODE_W = 4;
    localparam int COUNT_W  = 4;
    localparam int LENGTH_W = 64;
    localparam int KEY_W    = 32;

    localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;
    localparam logic [OPCODE_W-1:0] OP_PING  = 4'h9;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [COUNT_W-1:0] EXT16_BYTES = 4'd2;
    localparam logic [COUNT_W-1:0] EXT64_BYTES = 4'd8;
    localparam logic [COUNT_W-1:0] KEY_BYTES   = 4'd4;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CLOSED  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        EV_DATA  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_PING  = 2'd2,
        EV_CLOSE = 2'd3
    } t_event;

    typedef struct packed {
        logic                valid;
        logic [BYTE_W-1:0]   payload_byte;
        t_event              event_kind;
        logic [OPCODE_W-1:0] frame_opcode;
        logic                final_fragment;
        logic                last_of_frame;
    } t_res;

endpackage

// ===== sv/wsfd_parser.sv =====
// ----------------------------------------------------------------------------
// wsfd_parser
// Frame header, length and key parser; unmasks payload bytes one per request.
// ----------------------------------------------------------------------------
module wsfd_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [wsfd_pkg::BYTE_W-1:0] i_byte,
    output wsfd_pkg::t_res              o_res
);

    wsfd_pkg::t_phase                      r_phase, n_phase;
    logic [wsfd_pkg::COUNT_W-1:0]          r_count, n_count;
    logic                                  r_fin, n_fin;
    logic [wsfd_pkg::OPCODE_W-1:0]         r_op, n_op;
    logic                                  r_masked, n_masked;
    logic [wsfd_pkg::LENGTH_W-1:0]         r_len, n_len;
    logic [wsfd_pkg::KEY_W-1:0]            r_key, n_key;
    logic [1:0]                            r_kphase, n_kphase;

    logic                                  len_done;
    logic                                  start;
    logic                                  last;
    logic [wsfd_pkg::BYTE_W-1:0]           key_byte;
    logic [6:0]                            len7;
    wsfd_pkg::t_res                        res;

    always_comb begin
        n_phase  = r_phase;
        n_count  = r_count;
        n_fin    = r_fin;
        n_op     = r_op;
        n_masked = r_masked;
        n_len    = r_len;
        n_key    = r_key;
        n_kphase = r_kphase;
        len_done = 1'b0;
        start    = 1'b0;
        last     = 1'b0;
        key_byte = '0;
        len7     = i_byte[6:0];
        res      = '0;

        unique case (r_phase)
            wsfd_pkg::PH_HDR0: begin
                n_fin   = i_byte[7];
                n_op    = i_byte[3:0];
                n_phase = wsfd_pkg::PH_HDR1;
            end
            wsfd_pkg::PH_HDR1: begin
                n_masked = i_byte[7];
                if (len7 == wsfd_pkg::LEN7_EXT16) begin
                    n_len   = '0;
                    n_count = wsfd_pkg::EXT16_BYTES;
                    n_phase = wsfd_pkg::PH_EXTLEN;
                end else if (len7 == wsfd_pkg::LEN7_EXT64) begin
                    n_len   = '0;
                    n_count = wsfd_pkg::EXT64_BYTES;
                    n_phase = wsfd_pkg::PH_EXTLEN;
                end else begin
                    n_len    = {{(wsfd_pkg::LENGTH_W-7){1'b0}}, len7};
                    len_done = 1'b1;
                end
            end
            wsfd_pkg::PH_EXTLEN: begin
                n_len    = {r_len[wsfd_pkg::LENGTH_W-9:0], i_byte};
                n_count  = r_count - 1'b1;
                len_done = (n_count == '0);
            end
            wsfd_pkg::PH_KEY: begin
                n_key   = {r_key[wsfd_pkg::KEY_W-9:0], i_byte};
                n_count = r_count - 1'b1;
                start   = (n_count == '0);
            end
            wsfd_pkg::PH_PAYLOAD: begin
                if (r_len != '0) begin
                    n_len = r_len - 1'b1;
                end
                last = (n_len == '0);
                if (last) begin
                    n_phase = wsfd_pkg::PH_HDR0;
                end
                if (r_op != wsfd_pkg::OP_PING) begin
                    // first key byte sits in the top bits
                    if (r_masked) begin
                        key_byte = r_key[{~r_kphase, 3'b000} +: 8];
                    end
                    n_kphase             = r_kphase + 1'b1;
                    res.valid            = 1'b1;
                    res.payload_byte     = i_byte ^ key_byte;
                    res.event_kind       = wsfd_pkg::EV_DATA;
                    res.last_of_frame    = last;
                end
            end
            default: begin
                n_phase = wsfd_pkg::PH_CLOSED;
            end
        endcase

        if (len_done) begin
            if (n_masked) begin
                n_count = wsfd_pkg::KEY_BYTES;
                n_key   = '0;
                n_phase = wsfd_pkg::PH_KEY;
            end else begin
                start = 1'b1;
            end
        end

        if (start) begin
            n_kphase          = '0;
            res.valid         = 1'b1;
            res.payload_byte  = '0;
            res.last_of_frame = 1'b1;
            if (n_op == wsfd_pkg::OP_CLOSE) begin
                n_phase        = wsfd_pkg::PH_CLOSED;
                res.event_kind = wsfd_pkg::EV_CLOSE;
            end else if (n_op == wsfd_pkg::OP_PING) begin
                n_phase        = (n_len != '0) ? wsfd_pkg::PH_PAYLOAD : wsfd_pkg::PH_HDR0;
                res.event_kind = wsfd_pkg::EV_PING;
            end else if (n_len == '0) begin
                n_phase        = wsfd_pkg::PH_HDR0;
                res.event_kind = wsfd_pkg::EV_EMPTY;
            end else begin
                n_phase   = wsfd_pkg::PH_PAYLOAD;
                res.valid = 1'b0;
            end
        end

        res.frame_opcode   = n_op;
        res.final_fragment = n_fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= wsfd_pkg::PH_HDR0;
            r_count  <= '0;
            r_fin    <= 1'b0;
            r_op     <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_key    <= '0;
            r_kphase <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_fin    <= n_fin;
            r_op     <= n_op;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_key    <= n_key;
            r_kphase <= n_kphase;
        end
    end

    assign o_res = res;

endmodule

// ===== sv/wsfd_out_buf.sv =====
// ----------------------------------------------------------------------------
// wsfd_out_buf
// Result register with a skid stage so the input side keeps moving.
// ----------------------------------------------------------------------------
module wsfd_out_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wsfd_pkg::t_res i_res,
    input  logic           i_stall,
    output logic           o_valid,
    output wsfd_pkg::t_res o_res,
    output logic           o_full
);

    logic           r_out_v;
    wsfd_pkg::t_res r_out;
    logic           r_sk_v;
    wsfd_pkg::t_res r_sk;
    logic           out_ready;

    assign out_ready = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (out_ready) begin
            if (r_sk_v) begin
                r_out_v <= 1'b1;
                r_sk_v  <= i_push;
            end else begin
                r_out_v <= i_push;
            end
        end else if (i_push) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            if (r_sk_v) begin
                r_out <= r_sk;
                r_sk  <= i_res;
            end else begin
                r_out <= i_res;
            end
        end else if (i_push) begin
            r_sk <= i_res;
        end
    end

    assign o_valid = r_out_v;
    assign o_res   = r_out;
    assign o_full  = r_sk_v;

endmodule

// ===== sv/websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side websocket frame parser and payload unmasker.
// ----------------------------------------------------------------------------
// input channel: one raw stream byte per request on i_in_byte, qualified by
// i_valid and held off by o_stall. frames sit back to back in the stream.
// output channel: at most one result per input byte on o_valid / i_stall;
// data bytes come out unmasked, and ping, close and empty data frames give
// a single event with last_of_frame set.
// throughput: one byte per cycle while o_stall is low; header, length, key and
// payload bytes each update the parser state in the cycle they are taken.
// a taken byte's result is registered in the output register or the skid stage.
// when the receiver stalls, one result waits in the output register and one
// more in the skid stage; o_stall rises only when the skid stage is full.
// reset (synchronous, active low) returns the parser to the first header
// byte and empties both output stages. after a close frame the block drops
// every byte without a result until the next reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [wsfd_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [wsfd_pkg::BYTE_W-1:0]    o_payload_byte,
    output logic [1:0]                     o_event_kind,
    output logic [wsfd_pkg::OPCODE_W-1:0]  o_frame_opcode,
    output logic                           o_final_fragment,
    output logic                           o_last_of_frame
);

    logic           accept;
    logic           skid_full;
    wsfd_pkg::t_res step_res;
    wsfd_pkg::t_res out_res;

    assign accept = i_valid && !skid_full;

    wsfd_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in_byte),
        .o_res   (step_res)
    );

    wsfd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && step_res.valid),
        .i_res   (step_res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_res   (out_res),
        .o_full  (skid_full)
    );

    assign o_stall          = skid_full;
    assign o_payload_byte   = out_res.payload_byte;
    assign o_event_kind     = out_res.event_kind;
    assign o_frame_opcode   = out_res.frame_opcode;
    assign o_final_fragment = out_res.final_fragment;
    assign o_last_of_frame  = out_res.last_of_frame;

    // skid stage only fills behind a held result
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(skid_full) |-> $past(o_valid && i_stall))
        else $error("skid stage filled while output was free");

    a_event_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_event_kind != wsfd_pkg::EV_DATA) |-> o_last_of_frame)
        else $error("event without last_of_frame");

    // close is the final result before reset
    a_close_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_event_kind == wsfd_pkg::EV_CLOSE) |=> !o_valid)
        else $error("result after close event");

endmodule

// ===== dv/websocket_frame_deframer_checker.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer_checker
// Watches both channels of the deframer. Each accepted stream byte goes
// through a local frame parser that builds the expected results. Each
// accepted result is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_checker import wsfd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  logic [BYTE_W-1:0]   i_in_byte,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  logic [BYTE_W-1:0]   i_payload_byte,
    input  logic [1:0]          i_event_kind,
    input  logic [OPCODE_W-1:0] i_frame_opcode,
    input  logic                i_final_fragment,
    input  logic                i_last_of_frame,
    output int                  o_fail_count,
    output int                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload;
        t_event              kind;
        logic [OPCODE_W-1:0] opcode;
        logic                fin;
        logic                last;
    } t_ws_result;

    t_ws_result deframed_q[$];
    int fails = 0;

    // parser state
    t_phase              phase;
    logic [COUNT_W-1:0]  hdr_left;
    logic                fin_q;
    logic [OPCODE_W-1:0] opcode_q;
    logic                masked_q;
    logic [LENGTH_W-1:0] remaining;
    logic [KEY_W-1:0]    key;
    logic [1:0]          key_idx;
    logic                closed_q;

    task automatic push_result(input logic [BYTE_W-1:0] data, input t_event kind,
                               input logic last);
        t_ws_result r;
        r.payload = data;
        r.kind    = kind;
        r.opcode  = opcode_q;
        r.fin     = fin_q;
        r.last    = last;
        deframed_q.push_back(r);
    endtask

    // header and key complete: decide what the frame gives
    task automatic start_frame();
        key_idx = 2'd0;
        if (opcode_q == OP_CLOSE) begin
            closed_q = 1'b1;
            phase    = PH_CLOSED;
            push_result(8'h00, EV_CLOSE, 1'b1);
        end else if (opcode_q == OP_PING) begin
            if (remaining != 0) begin
                phase = PH_PAYLOAD;
            end else begin
                phase = PH_HDR0;
            end
            push_result(8'h00, EV_PING, 1'b1);
        end else if (remaining == 0) begin
            phase = PH_HDR0;
            push_result(8'h00, EV_EMPTY, 1'b1);
        end else begin
            phase = PH_PAYLOAD;
        end
    endtask

    task automatic end_of_length();
        if (masked_q) begin
            hdr_left = KEY_BYTES;
            key      = '0;
            phase    = PH_KEY;
        end else begin
            start_frame();
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [6:0]        len7;
        logic [BYTE_W-1:0] key_byte;
        logic              last;
        if (!closed_q) begin
            case (phase)
                PH_HDR0: begin
                    fin_q    = b[7];
                    opcode_q = b[3:0];
                    phase    = PH_HDR1;
                end
                PH_HDR1: begin
                    masked_q = b[7];
                    len7     = b[6:0];
                    if (len7 == LEN7_EXT16) begin
                        remaining = '0;
                        hdr_left  = EXT16_BYTES;
                        phase     = PH_EXTLEN;
                    end else if (len7 == LEN7_EXT64) begin
                        remaining = '0;
                        hdr_left  = EXT64_BYTES;
                        phase     = PH_EXTLEN;
                    end else begin
                        remaining = {57'd0, len7};
                        end_of_length();
                    end
                end
                PH_EXTLEN: begin
                    remaining = {remaining[LENGTH_W-9:0], b};
                    hdr_left  = hdr_left - 1'b1;
                    if (hdr_left == 0) begin
                        end_of_length();
                    end
                end
                PH_KEY: begin
                    key      = {key[KEY_W-9:0], b};
                    hdr_left = hdr_left - 1'b1;
                    if (hdr_left == 0) begin
                        start_frame();
                    end
                end
                PH_PAYLOAD: begin
                    if (remaining != 0) begin
                        remaining = remaining - 1'b1;
                    end
                    last = (remaining == 0);
                    if (last) begin
                        phase = PH_HDR0;
                    end
                    // ping payload is swallowed
                    if (opcode_q != OP_PING) begin
                        key_byte = masked_q ? key[8*(3-key_idx) +: 8] : 8'h00;
                        key_idx  = key_idx + 1'b1;
                        push_result(b ^ key_byte, EV_DATA, last);
                    end
                end
                default: begin
                    phase    = PH_CLOSED;
                    closed_q = 1'b1;
                end
            endcase
        end
    endtask

    task automatic check_field(input string field, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, field, want, got);
            fails++;
        end
    endtask

    task automatic check_result();
        t_ws_result want;
        if (deframed_q.size() == 0) begin
            $display({"%0t ns: unexpected result, expected none, actual byte 0x%02h",
                      " kind %0d opcode 0x%0h fin %0d last %0d"},
                     $time, i_payload_byte, i_event_kind, i_frame_opcode,
                     i_final_fragment, i_last_of_frame);
            fails++;
        end else begin
            want = deframed_q.pop_front();
            check_field("payload_byte", want.payload, i_payload_byte);
            check_field("event_kind", {6'd0, want.kind}, {6'd0, i_event_kind});
            check_field("frame_opcode", {4'd0, want.opcode}, {4'd0, i_frame_opcode});
            check_field("final_fragment", {7'd0, want.fin}, {7'd0, i_final_fragment});
            check_field("last_of_frame", {7'd0, want.last}, {7'd0, i_last_of_frame});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = PH_HDR0;
            hdr_left  = '0;
            fin_q     = 1'b0;
            opcode_q  = '0;
            masked_q  = 1'b0;
            remaining = '0;
            key       = '0;
            key_idx   = 2'd0;
            closed_q  = 1'b0;
            deframed_q.delete();
        end else begin
            // predict first so a same-edge result would still find its entry
            if (i_in_valid && !i_in_stall) begin
                decode_byte(i_in_byte);
            end
            if (i_out_valid && !i_out_stall) begin
                check_result();
            end
        end
        o_pending    <= deframed_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tb_websocket_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_websocket_frame_deframer_top
// Drives frame streams into the deframer with random request gaps and output
// stalls: a few hand-built frames, then random frames of every opcode but
// close, every length form and masking, and a close frame with bytes to drop.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import wsfd_pkg::*;

    localparam logic [OPCODE_W-1:0] OPC_CONT   = 4'h0;
    localparam logic [OPCODE_W-1:0] OPC_TEXT   = 4'h1;
    localparam logic [OPCODE_W-1:0] OPC_BINARY = 4'h2;
    localparam logic [OPCODE_W-1:0] OPC_PONG   = 4'hA;
    localparam logic [OPCODE_W-1:0] OPC_RSVD   = 4'hF;

    localparam int RANDOM_BYTES   = 1600;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    typedef enum int {
        LEN_SHORT,
        LEN_EXT16,
        LEN_EXT64
    } t_len_form;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [BYTE_W-1:0]   i_in_byte;
    logic                o_valid;
    logic                i_stall;
    logic [BYTE_W-1:0]   o_payload_byte;
    logic [1:0]          o_event_kind;
    logic [OPCODE_W-1:0] o_frame_opcode;
    logic                o_final_fragment;
    logic                o_last_of_frame;

    int fail_count;
    int pending;
    int sent_bytes  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    logic [BYTE_W-1:0] frame_body[$];

    websocket_frame_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_in_byte        (i_in_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_payload_byte   (o_payload_byte),
        .o_event_kind     (o_event_kind),
        .o_frame_opcode   (o_frame_opcode),
        .o_final_fragment (o_final_fragment),
        .o_last_of_frame  (o_last_of_frame)
    );

    websocket_frame_deframer_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_in_byte        (i_in_byte),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_payload_byte   (o_payload_byte),
        .i_event_kind     (o_event_kind),
        .i_frame_opcode   (o_frame_opcode),
        .i_final_fragment (o_final_fragment),
        .i_last_of_frame  (o_last_of_frame),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        else if (r < 85) return $urandom_range(1, 3);
        else if (r < 97) return $urandom_range(4, 12);
        else return $urandom_range(20, 60);
    endfunction

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 99) == 0) begin
                burst_left = $urandom_range(30, 120);
            end
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sent_bytes++;
    endtask

    // header, length, key, then the raw payload held in frame_body
    task automatic send_ws_frame(input logic [OPCODE_W-1:0] opcode, input logic fin,
                                 input logic [2:0] rsv, input logic mask,
                                 input t_len_form form, input logic [KEY_W-1:0] key);
        logic [LENGTH_W-1:0] len;
        len = LENGTH_W'(frame_body.size());
        send_byte({fin, rsv, opcode});
        case (form)
            LEN_SHORT: begin
                send_byte({mask, len[6:0]});
            end
            LEN_EXT16: begin
                send_byte({mask, LEN7_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default: begin
                send_byte({mask, LEN7_EXT64});
                for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
            end
        endcase
        if (mask) begin
            for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
        end
        foreach (frame_body[i]) send_byte(frame_body[i]);
    endtask

    // receiver stalls, with calm stretches
    initial begin
        int hold;
        i_stall = 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                @(negedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(negedge i_clk);
            end else begin
                hold = idle_len();
                if (hold > 0) begin
                    @(negedge i_clk);
                    i_stall <= 1'b1;
                    repeat (hold - 1) @(negedge i_clk);
                end
                @(negedge i_clk);
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int r;
        int len;
        int start_count;
        logic [OPCODE_W-1:0] opc;
        t_len_form form;

        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_in_byte = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reserved opcode with every reserved bit set, 16-bit length form
        frame_body = '{8'h00, 8'hFF};
        send_ws_frame(OPC_RSVD, 1'b1, 3'b111, 1'b0, LEN_EXT16, '0);
        // masked, 64-bit length form, payload runs past one key cycle
        frame_body = '{8'h00, 8'hFF, 8'h3C, 8'hC3, 8'h81};
        send_ws_frame(OPC_BINARY, 1'b0, 3'b000, 1'b1, LEN_EXT64, 32'hFF00A55A);
        // masked empty data frame: event on the last key byte
        frame_body.delete();
        send_ws_frame(OPC_CONT, 1'b1, 3'b000, 1'b1, LEN_SHORT, 32'h12345678);
        // ping payload gives nothing
        frame_body = '{8'hAA, 8'h55};
        send_ws_frame(OP_PING, 1'b1, 3'b000, 1'b0, LEN_SHORT, '0);
        frame_body.delete();
        send_ws_frame(OP_PING, 1'b1, 3'b000, 1'b1, LEN_SHORT, 32'hFFFFFFFF);
        // pong is handled as data
        send_ws_frame(OPC_PONG, 1'b1, 3'b000, 1'b0, LEN_SHORT, '0);

        start_count = sent_bytes;
        while (sent_bytes - start_count < RANDOM_BYTES) begin
            r = $urandom_range(0, 9);
            if (r < 6) begin
                case ($urandom_range(0, 2))
                    0: opc = OPC_CONT;
                    1: opc = OPC_TEXT;
                    default: opc = OPC_BINARY;
                endcase
            end else if (r < 8) begin
                opc = OP_PING;
            end else if (r == 8) begin
                opc = OPC_PONG;
            end else begin
                do opc = OPCODE_W'($urandom_range(3, 15)); while (opc == OP_CLOSE);
            end

            r = $urandom_range(0, 19);
            if (r < 8) len = $urandom_range(1, 12);
            else if (r < 10) len = 0;
            else if (r < 16) len = $urandom_range(13, 125);
            else len = $urandom_range(126, 300);

            r = $urandom_range(0, 19);
            if (len > 125) begin
                if (r < 15) form = LEN_EXT16;
                else form = LEN_EXT64;
            end else if (r < 17) begin
                form = LEN_SHORT;
            end else if (r < 19) begin
                form = LEN_EXT16;
            end else begin
                form = LEN_EXT64;
            end

            frame_body.delete();
            repeat (len) frame_body.push_back(BYTE_W'($urandom_range(0, 255)));
            send_ws_frame(opc, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), form, $urandom);
        end

        // close ends the stream: its payload and all later bytes are dropped
        frame_body.delete();
        repeat (3) frame_body.push_back(BYTE_W'($urandom_range(0, 255)));
        send_ws_frame(OP_CLOSE, 1'b1, 3'b000, 1'b1, LEN_SHORT, $urandom);
        frame_body = '{8'h48, 8'h69};
        send_ws_frame(OPC_TEXT, 1'b1, 3'b000, 1'b0, LEN_SHORT, '0);
        repeat (12) send_byte(BYTE_W'($urandom_range(0, 255)));

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
